// ===== hw/rtl/bpvgl_pkg.sv =====
// ============================================================================
// bpvgl_pkg
// shared types, constants and helpers for the bloch phase value/grad/laplacian
// ============================================================================
`default_nettype none

package bpvgl_pkg;

    localparam int C_MAX_BANDS    = 4096;
    localparam int C_CORDIC_STEPS = 16;
    localparam int C_ATAN_N       = 24;

    // 1/(2 pi) as a 32-bit fraction of a turn per radian
    localparam logic signed [30:0] C_INV_TWO_PI = 31'sd683565276;
    // cordic start value, pre-scaled by the inverse gain, q.30
    localparam logic signed [32:0] C_GAIN       = 33'sd652032874;
    localparam logic signed [31:0] C_EIGHTH     = 32'sd536870912;
    localparam logic [31:0]        C_QTR_HALF   = 32'h2000_0000;

    // arctan(2^-i) in 32-bit fractions of a turn
    localparam logic signed [31:0] C_ATAN [C_ATAN_N] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_LAT0   = 3'd0,
        REG_LAT1   = 3'd1,
        REG_LAT2   = 3'd2,
        REG_MET_A  = 3'd3,
        REG_MET_B  = 3'd4,
        REG_POS    = 3'd5,
        REG_NCPLX  = 3'd6
    } t_reg_idx;

    // quadrant of the reduced phase
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // per-band data carried alongside the cordic
    typedef struct packed {
        logic [12:0]        slot;
        logic               cplx;
        logic [15:0]        vr;
        logic [15:0]        vi;
        logic [2:0][34:0]   gr;
        logic [2:0][34:0]   gi;
        logic [43:0]        lr;
        logic [43:0]        li;
    } t_carry;

    // round half up by 2^n, then saturate to 16 bits
    function automatic logic [15:0] rnd_sat(input logic signed [63:0] v, input int n);
        logic signed [63:0] t;
        logic [15:0]        r;
        t = (v + (64'sd1 <<< (n - 1))) >>> n;
        if (t > 64'sd32767) begin
            r = 16'h7FFF;
        end else if (t < -64'sd32768) begin
            r = 16'h8000;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bloch_phase_value_grad_laplacian.sv =====
// ============================================================================
// bloch_phase_value_grad_laplacian
// phased cartesian value, gradient and laplacian of one orbital band per item
// ============================================================================
// usage:
//   - input channel (i_valid/o_ready) takes one band per item: index, k vector,
//     kk term, complex spline value, lattice-frame gradient and hessian
//   - output channel (o_valid/i_ready) returns one result item per band below
//     the band limit; bands at or above it are taken and dropped
//   - lattice, metric, position and complex band count are written over the
//     apb port (64-bit registers at byte address 8*index) while idle
//   - fully pipelined: one item per cycle while the receiver takes results,
//     with one cordic stage per step
//   - when the receiver stalls with a result waiting, the whole pipeline
//     holds and o_ready drops; nothing is lost or repeated
//   - reset clears the registers to zero and empties the pipeline
// ============================================================================
`default_nettype none

module bloch_phase_value_grad_laplacian #(
    parameter int CORDIC_STEPS = bpvgl_pkg::C_CORDIC_STEPS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // apb configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [5:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic      [63:0]   prdata,
    output logic               pready,
    // input channel
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [11:0]   i_band_index,
    input  wire logic [47:0]   i_k_vec,
    input  wire logic signed [15:0] i_k_sq,
    input  wire logic [31:0]   i_value,
    input  wire logic [47:0]   i_grad_re,
    input  wire logic [47:0]   i_grad_im,
    input  wire logic [47:0]   i_hess_re_lo,
    input  wire logic [47:0]   i_hess_re_hi,
    input  wire logic [47:0]   i_hess_im_lo,
    input  wire logic [47:0]   i_hess_im_hi,
    // output channel
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [12:0]        o_slot_index,
    output logic signed [15:0] o_psi_re,
    output logic signed [15:0] o_psi_im,
    output logic [47:0]        o_cart_grad_re,
    output logic [47:0]        o_cart_grad_im,
    output logic signed [15:0] o_lap_re,
    output logic signed [15:0] o_lap_im
);

    localparam int L_STEPS = (CORDIC_STEPS < bpvgl_pkg::C_ATAN_N) ?
                             CORDIC_STEPS : bpvgl_pkg::C_ATAN_N;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [47:0] r_lat [3];
    logic [63:0] r_met_a;
    logic [31:0] r_met_b;
    logic [47:0] r_pos;
    logic [12:0] r_ncplx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat[0] <= '0;
            r_lat[1] <= '0;
            r_lat[2] <= '0;
            r_met_a  <= '0;
            r_met_b  <= '0;
            r_pos    <= '0;
            r_ncplx  <= '0;
        end else if (w_wr) begin
            case (paddr[5:3])
                bpvgl_pkg::REG_LAT0:  r_lat[0] <= pwdata[47:0];
                bpvgl_pkg::REG_LAT1:  r_lat[1] <= pwdata[47:0];
                bpvgl_pkg::REG_LAT2:  r_lat[2] <= pwdata[47:0];
                bpvgl_pkg::REG_MET_A: r_met_a  <= pwdata;
                bpvgl_pkg::REG_MET_B: r_met_b  <= pwdata[31:0];
                bpvgl_pkg::REG_POS:   r_pos    <= pwdata[47:0];
                bpvgl_pkg::REG_NCPLX: r_ncplx  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            bpvgl_pkg::REG_LAT0:  prdata = {16'h0, r_lat[0]};
            bpvgl_pkg::REG_LAT1:  prdata = {16'h0, r_lat[1]};
            bpvgl_pkg::REG_LAT2:  prdata = {16'h0, r_lat[2]};
            bpvgl_pkg::REG_MET_A: prdata = r_met_a;
            bpvgl_pkg::REG_MET_B: prdata = {32'h0, r_met_b};
            bpvgl_pkg::REG_POS:   prdata = {16'h0, r_pos};
            bpvgl_pkg::REG_NCPLX: prdata = {51'h0, r_ncplx};
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline advance: everything moves unless a finished result is stuck
    // ------------------------------------------------------------------
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // unpacked views of the packed fields
    logic signed [15:0] w_k [3];
    logic signed [15:0] w_p [3];
    logic signed [15:0] w_dre [3];
    logic signed [15:0] w_dim [3];
    logic signed [15:0] w_hre [6];
    logic signed [15:0] w_him [6];
    logic signed [15:0] w_m [6];
    logic signed [15:0] w_g [3][3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_k[a]       = $signed(i_k_vec[16*a +: 16]);
            w_p[a]       = $signed(r_pos[16*a +: 16]);
            w_dre[a]     = $signed(i_grad_re[16*a +: 16]);
            w_dim[a]     = $signed(i_grad_im[16*a +: 16]);
            w_hre[a]     = $signed(i_hess_re_lo[16*a +: 16]);
            w_hre[a + 3] = $signed(i_hess_re_hi[16*a +: 16]);
            w_him[a]     = $signed(i_hess_im_lo[16*a +: 16]);
            w_him[a + 3] = $signed(i_hess_im_hi[16*a +: 16]);
            for (int b = 0; b < 3; b++) begin
                w_g[a][b] = $signed(r_lat[a][16*b +: 16]);
            end
        end
        for (int a = 0; a < 4; a++) begin
            w_m[a] = $signed(r_met_a[16*a +: 16]);
        end
        w_m[4] = $signed(r_met_b[15:0]);
        w_m[5] = $signed(r_met_b[31:16]);
    end

    // ------------------------------------------------------------------
    // stage 1: all 16x16 products
    // ------------------------------------------------------------------
    logic               r1_v;
    logic [12:0]        r1_slot;
    logic               r1_cplx;
    logic signed [15:0] r1_vr, r1_vi;
    logic signed [15:0] r1_k [3];
    logic signed [31:0] r1_pk [3];
    logic signed [31:0] r1_gre [3][3];
    logic signed [31:0] r1_gim [3][3];
    logic signed [31:0] r1_vik [3];
    logic signed [31:0] r1_vrk [3];
    logic signed [31:0] r1_kvr, r1_kvi;
    logic signed [31:0] r1_hr [6];
    logic signed [31:0] r1_hi [6];
    logic               w_in_ok;
    logic               w_cplx;
    logic signed [15:0] w_vr, w_vi;

    assign w_in_ok = (32'(i_band_index) < bpvgl_pkg::C_MAX_BANDS);
    assign w_cplx  = ({1'b0, i_band_index} < r_ncplx);
    assign w_vr    = $signed(i_value[15:0]);
    assign w_vi    = $signed(i_value[31:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid && w_in_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // complex bands go to 2j, real bands after the complex block
            r1_slot <= w_cplx ? {i_band_index, 1'b0} : (r_ncplx + {1'b0, i_band_index});
            r1_cplx <= w_cplx;
            r1_vr   <= w_vr;
            r1_vi   <= w_vi;
            r1_kvr  <= i_k_sq * w_vr;
            r1_kvi  <= i_k_sq * w_vi;
            for (int a = 0; a < 3; a++) begin
                r1_k[a]   <= w_k[a];
                r1_pk[a]  <= w_p[a] * w_k[a];
                r1_vik[a] <= w_vi * w_k[a];
                r1_vrk[a] <= w_vr * w_k[a];
                for (int b = 0; b < 3; b++) begin
                    r1_gre[a][b] <= w_g[a][b] * w_dre[b];
                    r1_gim[a][b] <= w_g[a][b] * w_dim[b];
                end
            end
            for (int a = 0; a < 6; a++) begin
                r1_hr[a] <= w_hre[a] * w_m[a];
                r1_hi[a] <= w_him[a] * w_m[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sums (negated phase, rotated gradient, hessian contraction)
    // ------------------------------------------------------------------
    logic               r2_v;
    logic [12:0]        r2_slot;
    logic               r2_cplx;
    logic signed [15:0] r2_vr, r2_vi;
    logic signed [15:0] r2_k [3];
    logic signed [34:0] r2_ph;
    logic signed [33:0] r2_dr [3];
    logic signed [33:0] r2_di [3];
    logic signed [34:0] r2_gr [3];
    logic signed [34:0] r2_gi [3];
    logic signed [35:0] r2_lp, r2_li;
    logic signed [33:0] w_dr [3];
    logic signed [33:0] w_di [3];
    logic signed [35:0] w_lp, w_li;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_dr[a] = 34'(r1_gre[a][0]) + 34'(r1_gre[a][1]) + 34'(r1_gre[a][2]);
            w_di[a] = 34'(r1_gim[a][0]) + 34'(r1_gim[a][1]) + 34'(r1_gim[a][2]);
        end
        w_lp = 36'(r1_kvr);
        w_li = 36'(r1_kvi);
        for (int a = 0; a < 6; a++) begin
            w_lp = w_lp + 36'(r1_hr[a]);
            w_li = w_li + 36'(r1_hi[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_slot <= r1_slot;
            r2_cplx <= r1_cplx;
            r2_vr   <= r1_vr;
            r2_vi   <= r1_vi;
            r2_ph   <= -(35'(r1_pk[0]) + 35'(r1_pk[1]) + 35'(r1_pk[2]));
            r2_lp   <= w_lp;
            r2_li   <= w_li;
            for (int a = 0; a < 3; a++) begin
                r2_k[a]  <= r1_k[a];
                r2_dr[a] <= w_dr[a];
                r2_di[a] <= w_di[a];
                r2_gr[a] <= 35'(w_dr[a]) + 35'(r1_vik[a]);
                r2_gi[a] <= 35'(w_di[a]) - 35'(r1_vrk[a]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: phase to turns, k-cross products
    // ------------------------------------------------------------------
    logic               r3_v;
    logic [12:0]        r3_slot;
    logic               r3_cplx;
    logic signed [15:0] r3_vr, r3_vi;
    logic signed [65:0] r3_prod;
    logic signed [49:0] r3_trp [3];
    logic signed [49:0] r3_tip [3];
    logic signed [34:0] r3_gr [3];
    logic signed [34:0] r3_gi [3];
    logic signed [35:0] r3_lp, r3_li;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_slot <= r2_slot;
            r3_cplx <= r2_cplx;
            r3_vr   <= r2_vr;
            r3_vi   <= r2_vi;
            r3_prod <= r2_ph * bpvgl_pkg::C_INV_TWO_PI;
            r3_lp   <= r2_lp;
            r3_li   <= r2_li;
            for (int a = 0; a < 3; a++) begin
                r3_trp[a] <= r2_k[a] * r2_di[a];
                r3_tip[a] <= r2_k[a] * r2_dr[a];
                r3_gr[a]  <= r2_gr[a];
                r3_gi[a]  <= r2_gi[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: turn fraction, quadrant and residual; laplacian terms
    // ------------------------------------------------------------------
    logic                   r4_v;
    logic [1:0]             r4_q;
    logic signed [31:0]     r4_z;
    bpvgl_pkg::t_carry      r4_c;
    logic [53:0]            w_tr54;
    logic [31:0]            w_cen;
    logic signed [51:0]     w_tr, w_ti;
    logic signed [40:0]     w_rtr, w_rti;
    bpvgl_pkg::t_carry      w_c4;

    always_comb begin
        w_tr54 = r3_prod[53:0] + 54'd2097152;
        w_cen  = w_tr54[53:22] + bpvgl_pkg::C_QTR_HALF;
        w_tr   = 52'(r3_trp[0]) + 52'(r3_trp[1]) + 52'(r3_trp[2]);
        w_ti   = 52'(r3_tip[0]) + 52'(r3_tip[1]) + 52'(r3_tip[2]);
        w_rtr  = 41'((w_tr + 52'sd1024) >>> 11);
        w_rti  = 41'((w_ti + 52'sd1024) >>> 11);
        w_c4.slot = r3_slot;
        w_c4.cplx = r3_cplx;
        w_c4.vr   = r3_vr;
        w_c4.vi   = r3_vi;
        for (int a = 0; a < 3; a++) begin
            w_c4.gr[a] = r3_gr[a];
            w_c4.gi[a] = r3_gi[a];
        end
        w_c4.lr = 44'(r3_lp) + (44'(w_rtr) <<< 1);
        w_c4.li = 44'(r3_li) - (44'(w_rti) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_q <= w_cen[31:30];
            r4_z <= $signed({2'b00, w_cen[29:0]}) - bpvgl_pkg::C_EIGHTH;
            r4_c <= w_c4;
        end
    end

    // ------------------------------------------------------------------
    // cordic: one rotation step per stage
    // ------------------------------------------------------------------
    logic signed [32:0]  w_x [L_STEPS + 1];
    logic signed [32:0]  w_y [L_STEPS + 1];
    logic signed [31:0]  w_z [L_STEPS + 1];
    logic [1:0]          w_q [L_STEPS + 1];
    logic                w_v [L_STEPS + 1];
    bpvgl_pkg::t_carry   w_cc [L_STEPS + 1];

    assign w_x[0]  = bpvgl_pkg::C_GAIN;
    assign w_y[0]  = '0;
    assign w_z[0]  = r4_z;
    assign w_q[0]  = r4_q;
    assign w_v[0]  = r4_v;
    assign w_cc[0] = r4_c;

    for (genvar k = 0; k < L_STEPS; k++) begin : g_cordic
        logic signed [32:0] r_x, r_y;
        logic signed [31:0] r_z;
        logic [1:0]         r_q;
        logic               r_v;
        bpvgl_pkg::t_carry  r_c;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_q <= w_q[k];
                r_c <= w_cc[k];
                if (w_z[k] >= 0) begin
                    r_x <= w_x[k] - (w_y[k] >>> k);
                    r_y <= w_y[k] + (w_x[k] >>> k);
                    r_z <= w_z[k] - bpvgl_pkg::C_ATAN[k];
                end else begin
                    r_x <= w_x[k] + (w_y[k] >>> k);
                    r_y <= w_y[k] - (w_x[k] >>> k);
                    r_z <= w_z[k] + bpvgl_pkg::C_ATAN[k];
                end
            end
        end

        assign w_x[k + 1]  = r_x;
        assign w_y[k + 1]  = r_y;
        assign w_z[k + 1]  = r_z;
        assign w_q[k + 1]  = r_q;
        assign w_v[k + 1]  = r_v;
        assign w_cc[k + 1] = r_c;
    end

    // ------------------------------------------------------------------
    // stage 5: round to q.14 and rotate by quadrant
    // ------------------------------------------------------------------
    logic               r5_v;
    logic signed [16:0] r5_cos, r5_sin;
    bpvgl_pkg::t_carry  r5_c;
    logic signed [16:0] w_cr, w_sr;
    logic signed [32:0] w_xr, w_yr;

    always_comb begin
        w_xr = (w_x[L_STEPS] + 33'sd32768) >>> 16;
        w_yr = (w_y[L_STEPS] + 33'sd32768) >>> 16;
        w_cr = w_xr[16:0];
        w_sr = w_yr[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= w_v[L_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_c <= w_cc[L_STEPS];
            case (bpvgl_pkg::t_quad'(w_q[L_STEPS]))
                bpvgl_pkg::QUAD_0: begin
                    r5_cos <= w_cr;
                    r5_sin <= w_sr;
                end
                bpvgl_pkg::QUAD_1: begin
                    r5_cos <= -w_sr;
                    r5_sin <= w_cr;
                end
                bpvgl_pkg::QUAD_2: begin
                    r5_cos <= -w_cr;
                    r5_sin <= -w_sr;
                end
                default: begin
                    r5_cos <= w_sr;
                    r5_sin <= -w_cr;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 6: phase products
    // ------------------------------------------------------------------
    logic               r6_v;
    logic [12:0]        r6_slot;
    logic               r6_cplx;
    logic signed [32:0] r6_cvr, r6_svi, r6_cvi, r6_svr;
    logic signed [51:0] r6_cgr [3];
    logic signed [51:0] r6_sgi [3];
    logic signed [51:0] r6_cgi [3];
    logic signed [51:0] r6_sgr [3];
    logic signed [60:0] r6_clr, r6_sli, r6_cli, r6_slr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_slot <= r5_c.slot;
            r6_cplx <= r5_c.cplx;
            r6_cvr  <= r5_cos * $signed(r5_c.vr);
            r6_svi  <= r5_sin * $signed(r5_c.vi);
            r6_cvi  <= r5_cos * $signed(r5_c.vi);
            r6_svr  <= r5_sin * $signed(r5_c.vr);
            r6_clr  <= r5_cos * $signed(r5_c.lr);
            r6_sli  <= r5_sin * $signed(r5_c.li);
            r6_cli  <= r5_cos * $signed(r5_c.li);
            r6_slr  <= r5_sin * $signed(r5_c.lr);
            for (int a = 0; a < 3; a++) begin
                r6_cgr[a] <= r5_cos * $signed(r5_c.gr[a]);
                r6_sgi[a] <= r5_sin * $signed(r5_c.gi[a]);
                r6_cgi[a] <= r5_cos * $signed(r5_c.gi[a]);
                r6_sgr[a] <= r5_sin * $signed(r5_c.gr[a]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 7: output register, round and saturate; real bands zero the
    // imaginary outputs
    // ------------------------------------------------------------------
    logic [47:0] w_gre, w_gim;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_gre[16*a +: 16] = bpvgl_pkg::rnd_sat(64'(r6_cgr[a]) - 64'(r6_sgi[a]), 25);
            w_gim[16*a +: 16] = bpvgl_pkg::rnd_sat(64'(r6_cgi[a]) + 64'(r6_sgr[a]), 25);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_slot_index   <= r6_slot;
            o_psi_re       <= bpvgl_pkg::rnd_sat(64'(r6_cvr) - 64'(r6_svi), 14);
            o_cart_grad_re <= w_gre;
            o_lap_re       <= bpvgl_pkg::rnd_sat(64'(r6_clr) - 64'(r6_sli), 25);
            if (r6_cplx) begin
                o_psi_im       <= bpvgl_pkg::rnd_sat(64'(r6_cvi) + 64'(r6_svr), 14);
                o_cart_grad_im <= w_gim;
                o_lap_im       <= bpvgl_pkg::rnd_sat(64'(r6_cli) + 64'(r6_slr), 25);
            end else begin
                o_psi_im       <= '0;
                o_cart_grad_im <= '0;
                o_lap_im       <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sim/bloch_phase_value_grad_laplacian_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bloch_phase_value_grad_laplacian_tb
// self-checking bench for the phased value, gradient and laplacian stage
// ============================================================================
// bands stream in over the input channel with random gaps. A local model
// builds the expected result of each untyped band: lattice rotation, metric
// contraction, k-cross terms and the cordic phase factor. Results are compared
// field by field, in order, while the receiver stalls at random. The lattice,
// metric, position and complex band count registers are rewritten over apb
// between phases, the extremes among them.
// ============================================================================
`default_nettype none

module bloch_phase_value_grad_laplacian_tb;

    localparam int  CLK_HALF      = 4;
    localparam int  TIMEOUT_CYC   = 600000;
    localparam int  PIPE_DRAIN    = 40;
    localparam int  N_PHASES      = 8;
    localparam int  ITEMS_PER_PH  = 150;
    localparam int  N_DIRECTED    = 20;
    localparam int  N_TYPED       = 8;
    localparam int  CORDIC_N      = (bpvgl_pkg::C_CORDIC_STEPS < 24) ?
                                    bpvgl_pkg::C_CORDIC_STEPS : 24;

    // arctan(2^-i) in 32-bit fractions of a turn
    localparam longint ATAN_TURN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        logic [11:0] band;
        logic [47:0] kv;
        logic [15:0] ksq;
        logic [31:0] val;
        logic [47:0] g_re;
        logic [47:0] g_im;
        logic [47:0] h_re_lo;
        logic [47:0] h_re_hi;
        logic [47:0] h_im_lo;
        logic [47:0] h_im_hi;
    } t_band_item;

    typedef struct {
        logic [12:0] slot;
        logic [15:0] psi_re;
        logic [15:0] psi_im;
        logic [47:0] grad_re;
        logic [47:0] grad_im;
        logic [15:0] lap_re;
        logic [15:0] lap_im;
    } t_band_result;

    typedef struct {
        t_band_item   item;
        bit           typed;
        t_band_result res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    wire  [63:0] prdata;
    wire         pready;
    logic        i_valid = 1'b0;
    wire         o_ready;
    logic [11:0] i_band_index = '0;
    logic [47:0] i_k_vec = '0;
    logic signed [15:0] i_k_sq = '0;
    logic [31:0] i_value = '0;
    logic [47:0] i_grad_re = '0;
    logic [47:0] i_grad_im = '0;
    logic [47:0] i_hess_re_lo = '0;
    logic [47:0] i_hess_re_hi = '0;
    logic [47:0] i_hess_im_lo = '0;
    logic [47:0] i_hess_im_hi = '0;
    wire         o_valid;
    logic        i_ready = 1'b0;
    wire  [12:0] o_slot_index;
    wire  signed [15:0] o_psi_re;
    wire  signed [15:0] o_psi_im;
    wire  [47:0] o_cart_grad_re;
    wire  [47:0] o_cart_grad_im;
    wire  signed [15:0] o_lap_re;
    wire  signed [15:0] o_lap_im;

    // shadow copy of the configuration registers
    logic [47:0] lat_row [3];
    logic [63:0] met_a;
    logic [31:0] met_b;
    logic [47:0] pos_xyz;
    logic [12:0] ncplx;

    t_band_result expected_q [$];
    int          mismatches = 0;
    int          n_results = 0;
    int          n_items = 0;
    int          n_cplx = 0;
    int          n_settings = 0;
    int          cycles = 0;
    bit          no_idle = 1'b0;   // both sides run flat out when set
    int          rx_stall = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    bloch_phase_value_grad_laplacian dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_band_index   (i_band_index),
        .i_k_vec        (i_k_vec),
        .i_k_sq         (i_k_sq),
        .i_value        (i_value),
        .i_grad_re      (i_grad_re),
        .i_grad_im      (i_grad_im),
        .i_hess_re_lo   (i_hess_re_lo),
        .i_hess_re_hi   (i_hess_re_hi),
        .i_hess_im_lo   (i_hess_im_lo),
        .i_hess_im_hi   (i_hess_im_hi),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_slot_index   (o_slot_index),
        .o_psi_re       (o_psi_re),
        .o_psi_im       (o_psi_im),
        .o_cart_grad_re (o_cart_grad_re),
        .o_cart_grad_im (o_cart_grad_im),
        .o_lap_re       (o_lap_re),
        .o_lap_im       (o_lap_im)
    );

    // ------------------------------------------------------------------
    // model of the datapath
    // ------------------------------------------------------------------

    // signed q4.11 field a of a packed word
    function automatic longint fld(logic [63:0] w, int a);
        logic signed [15:0] f;
        f = w[16*a +: 16];
        return longint'(f);
    endfunction

    // round half up by 2^n, then clamp to 16 bits
    function automatic logic [15:0] round_clamp(longint v, int n);
        longint t;
        t = (v + (longint'(1) <<< (n - 1))) >>> n;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return t[15:0];
    endfunction

    // sine and cosine in q.14 of a q.22 phase in radians
    function automatic void phase_sin_cos(longint ang, output longint s, output longint c);
        longint           prod, x, y, z, dx, dy, cc, ss;
        logic [63:0]      rnd;
        logic [31:0]      turn, centered;
        bpvgl_pkg::t_quad quad;
        prod = ang * 64'sd683565276;
        rnd = prod + 64'd2097152;
        turn = rnd[53:22];
        centered = turn + 32'h2000_0000;
        quad = bpvgl_pkg::t_quad'(centered[31:30]);
        z = longint'({34'd0, centered[29:0]}) - 536870912;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TURN[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TURN[i];
            end
        end
        cc = (x + 32768) >>> 16;
        ss = (y + 32768) >>> 16;
        case (quad)
            bpvgl_pkg::QUAD_0: begin c = cc;  s = ss;  end
            bpvgl_pkg::QUAD_1: begin c = -ss; s = cc;  end
            bpvgl_pkg::QUAD_2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    function automatic t_band_result phased_band(t_band_item it);
        t_band_result r;
        longint k [3];
        longint dr [3];
        longint di [3];
        longint gr [3];
        longint gi [3];
        longint m [6];
        longint hr [6];
        longint hi [6];
        longint kk, vr, vi, tr, ti, lr, li, ph, s, c;
        bit     cplx;
        cplx = {1'b0, it.band} < ncplx;
        for (int a = 0; a < 3; a++) k[a] = fld(it.kv, a);
        kk = fld(it.ksq, 0);
        vr = fld(it.val, 0);
        vi = fld(it.val, 1);
        for (int a = 0; a < 4; a++) m[a] = fld(met_a, a);
        m[4] = fld(met_b, 0);
        m[5] = fld(met_b, 1);
        for (int a = 0; a < 3; a++) begin
            hr[a] = fld(it.h_re_lo, a); hr[a+3] = fld(it.h_re_hi, a);
            hi[a] = fld(it.h_im_lo, a); hi[a+3] = fld(it.h_im_hi, a);
        end
        ph = 0;
        for (int a = 0; a < 3; a++) ph += fld(pos_xyz, a) * k[a];
        phase_sin_cos(-ph, s, c);
        tr = 0;
        ti = 0;
        for (int a = 0; a < 3; a++) begin
            dr[a] = 0;
            di[a] = 0;
            for (int b = 0; b < 3; b++) begin
                dr[a] += fld(lat_row[a], b) * fld(it.g_re, b);
                di[a] += fld(lat_row[a], b) * fld(it.g_im, b);
            end
            gr[a] = dr[a] + vi * k[a];
            gi[a] = di[a] - vr * k[a];
            tr += k[a] * di[a];
            ti += k[a] * dr[a];
        end
        // k-cross terms come back to q.22 before doubling
        lr = kk * vr + 2 * ((tr + 1024) >>> 11);
        li = kk * vi - 2 * ((ti + 1024) >>> 11);
        for (int a = 0; a < 6; a++) begin
            lr += hr[a] * m[a];
            li += hi[a] * m[a];
        end
        r.psi_re = round_clamp(c * vr - s * vi, 14);
        r.lap_re = round_clamp(c * lr - s * li, 25);
        for (int a = 0; a < 3; a++)
            r.grad_re[16*a +: 16] = round_clamp(c * gr[a] - s * gi[a], 25);
        if (cplx) begin
            r.slot = {it.band, 1'b0};
            r.psi_im = round_clamp(c * vi + s * vr, 14);
            r.lap_im = round_clamp(c * li + s * lr, 25);
            for (int a = 0; a < 3; a++)
                r.grad_im[16*a +: 16] = round_clamp(c * gi[a] + s * gr[a], 25);
        end else begin
            r.slot = ncplx + {1'b0, it.band};
            r.psi_im = '0;
            r.lap_im = '0;
            r.grad_im = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one q4.11 number: mostly full range, some small, some at the rails
    function automatic logic [15:0] rand_q(bit small_only);
        int sel;
        sel = small_only ? 4 : $urandom_range(0, 7);
        case (sel)
            4, 5:    return 16'($signed($urandom_range(0, 4095)) - 2048);
            6:       return 16'h7FFF;
            7:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_q3(bit small_only);
        return {rand_q(small_only), rand_q(small_only), rand_q(small_only)};
    endfunction

    function automatic t_band_item rand_band();
        t_band_item it;
        bit         sm;
        sm = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 5))
            0:       it.band = 12'(ncplx) - 12'($urandom_range(0, 2)); // around the split
            1:       it.band = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
            default: it.band = 12'($urandom);
        endcase
        it.kv      = rand_q3(sm);
        it.ksq     = rand_q(sm);
        it.val     = {rand_q(sm), rand_q(sm)};
        it.g_re    = rand_q3(sm);
        it.g_im    = rand_q3(sm);
        it.h_re_lo = rand_q3(sm);
        it.h_re_hi = rand_q3(sm);
        it.h_im_lo = rand_q3(sm);
        it.h_im_hi = rand_q3(sm);
        return it;
    endfunction

    // apb write: setup cycle, then access cycle; shadow follows the register
    task automatic reg_write(bpvgl_pkg::t_reg_idx idx, logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bpvgl_pkg::REG_LAT0:  lat_row[0] = data[47:0];
            bpvgl_pkg::REG_LAT1:  lat_row[1] = data[47:0];
            bpvgl_pkg::REG_LAT2:  lat_row[2] = data[47:0];
            bpvgl_pkg::REG_MET_A: met_a = data;
            bpvgl_pkg::REG_MET_B: met_b = data[31:0];
            bpvgl_pkg::REG_POS:   pos_xyz = data[47:0];
            bpvgl_pkg::REG_NCPLX: ncplx = data[12:0];
            default: ;
        endcase
    endtask

    // mode 0: all positive rails, 1: all negative rails, else random
    task automatic load_setting(int mode, logic [12:0] bands_cplx);
        logic [63:0] w [6];
        bit          sm;
        sm = ($urandom_range(0, 1) != 0);
        for (int r = 0; r < 6; r++) begin
            case (mode)
                0:       w[r] = {4{16'h7FFF}};
                1:       w[r] = {4{16'h8000}};
                default: w[r] = {rand_q(sm), rand_q3(sm)};
            endcase
        end
        reg_write(bpvgl_pkg::REG_LAT0, w[0]);
        reg_write(bpvgl_pkg::REG_LAT1, w[1]);
        reg_write(bpvgl_pkg::REG_LAT2, w[2]);
        reg_write(bpvgl_pkg::REG_MET_A, w[3]);
        reg_write(bpvgl_pkg::REG_MET_B, w[4]);
        reg_write(bpvgl_pkg::REG_POS, w[5]);
        reg_write(bpvgl_pkg::REG_NCPLX, {51'd0, bands_cplx});
        n_settings++;
    endtask

    // offer one band, hold it until taken, then queue what it should give
    task automatic send_band(t_band_item it, bit typed, t_band_result typed_res);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_band_index <= it.band;
        i_k_vec      <= it.kv;
        i_k_sq       <= it.ksq;
        i_value      <= it.val;
        i_grad_re    <= it.g_re;
        i_grad_im    <= it.g_im;
        i_hess_re_lo <= it.h_re_lo;
        i_hess_re_hi <= it.h_re_hi;
        i_hess_im_lo <= it.h_im_lo;
        i_hess_im_hi <= it.h_im_hi;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.push_back(typed ? typed_res : phased_band(it));
        n_items++;
        if ({1'b0, it.band} < ncplx) n_cplx++;
    endtask

    // drain: every result back, then let the pipeline settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // receiver, checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_band_result e;
        bit           bad;
        bit           next_ready;
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYC) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_q.size());
            $display("FAILED: results differ");
            $finish;
        end
        next_ready = i_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item at slot %0d", o_slot_index);
                end else begin
                    e = expected_q.pop_front();
                    bad = (o_slot_index !== e.slot) || (o_psi_re !== e.psi_re) ||
                          (o_psi_im !== e.psi_im) || (o_cart_grad_re !== e.grad_re) ||
                          (o_cart_grad_im !== e.grad_im) || (o_lap_re !== e.lap_re) ||
                          (o_lap_im !== e.lap_im);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp slot %0d psi %h %h grad %h %h lap %h %h",
                                     e.slot, e.psi_re, e.psi_im, e.grad_re, e.grad_im,
                                     e.lap_re, e.lap_im);
                            $display("          got slot %0d psi %h %h grad %h %h lap %h %h",
                                     o_slot_index, o_psi_re, o_psi_im, o_cart_grad_re,
                                     o_cart_grad_im, o_lap_re, o_lap_im);
                        end
                    end
                end
                // new stall length for the next item
                rx_stall = no_idle ? 0 : $urandom_range(0, 14);
                next_ready = (rx_stall == 0);
            end else if (rx_stall > 0) begin
                rx_stall--;
                next_ready = (rx_stall == 0);
            end else begin
                next_ready = 1'b1;
            end
        end
        i_ready <= next_ready;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    t_stim_row    directed [N_DIRECTED];
    t_band_result zero_res;

    initial begin
        lat_row[0] = '0; lat_row[1] = '0; lat_row[2] = '0;
        met_a = '0; met_b = '0; pos_xyz = '0; ncplx = '0;

        // after reset every register is zero: a zero value leaves nothing
        // but a real band with all-zero parts, whatever the other fields hold
        for (int r = 0; r < N_DIRECTED; r++) begin
            directed[r].item = rand_band();
            directed[r].typed = (r < N_TYPED);
        end
        for (int r = 0; r < N_TYPED; r++) begin
            directed[r].item.val = '0;
            zero_res = '{default: '0};
            directed[r].item.band = (r == 0) ? 12'h000 : (r == 1) ? 12'hFFF : directed[r].item.band;
            zero_res.slot = {1'b0, directed[r].item.band};
            directed[r].res = zero_res;
        end
        // fields at the rails with reset configuration
        directed[2].item.kv = {3{16'h7FFF}};  directed[2].item.ksq = 16'h7FFF;
        directed[3].item.kv = {3{16'h8000}};  directed[3].item.ksq = 16'h8000;
        directed[4].item.g_re = {3{16'h7FFF}}; directed[4].item.h_re_lo = {3{16'h8000}};
        directed[5].item.g_im = {3{16'h8000}}; directed[5].item.h_im_hi = {3{16'h7FFF}};
        // predicted rows, run with the positive-rail setting and a split at 2048
        directed[8].item.band  = 12'd0;
        directed[9].item.band  = 12'd2047;                         // last complex band
        directed[10].item.band = 12'd2048;                         // first real band
        directed[11].item.band = 12'hFFF;
        directed[12].item.kv   = '0;                               // zero phase
        directed[13].item.val  = {16'h7FFF, 16'h7FFF};
        directed[14].item.val  = {16'h8000, 16'h8000};
        directed[15].item.kv   = {3{16'h7FFF}};
        directed[16].item.kv   = {3{16'h8000}};
        directed[17].item.h_re_lo = {3{16'h7FFF}}; directed[17].item.h_re_hi = {3{16'h7FFF}};
        directed[18].item.g_re = {3{16'h8000}}; directed[18].item.g_im = {3{16'h7FFF}};
        directed[19].item.ksq  = 16'h8000;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (r == N_TYPED) begin
                wait_idle();
                load_setting(0, 13'd2048);
            end
            send_band(directed[r].item, directed[r].typed, directed[r].res);
        end

        // random phases: rails first, then random settings; split at 0, all
        // complex, and random points between
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            case (p)
                0:       load_setting(1, 13'd0);
                1:       load_setting(0, 13'd4096);
                default: load_setting(2, 13'($urandom_range(0, 4096)));
            endcase
            no_idle = (p % 3 == 2);
            for (int n = 0; n < ITEMS_PER_PH; n++)
                send_band(rand_band(), 1'b0, zero_res);
        end
        wait_idle();

        $display("%0d bands sent (%0d complex) over %0d register settings, %0d results seen",
                 n_items, n_cplx, n_settings, n_results);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
